// ===== design/cdll_pkg.sv =====
// shared constants and types for the cursor doubly linked list engine
// no dependencies
`default_nettype none
package cdll_pkg;
   localparam int CAPACITY_DEF   = 256;
   localparam int DATA_WIDTH_DEF = 32;
   localparam int OP_W     = 4;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 8;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 9;

   typedef enum logic [OP_W-1:0] {
      OP_INS_BEFORE = 4'd0,
      OP_INS_AFTER  = 4'd1,
      OP_DELETE     = 4'd2,
      OP_NEXT       = 4'd3,
      OP_PREV       = 4'd4,
      OP_FIRST      = 4'd5,
      OP_LAST       = 4'd6,
      OP_READ       = 4'd7,
      OP_WRITE      = 4'd8,
      OP_INDEX_READ = 4'd9
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_RANGE = 2'd3
   } status_type;
endpackage
`default_nettype wire

// ===== design/cursor_doubly_linked_list_engine.sv =====
// cursor doubly linked list engine: sequencer over a shared node memory port
// index_read and max read walk the list one node per cycle through the single
// read port; the next word can be taken in the cycle rsp_valid rises, and a
// stalled response word holds the following item in S_OUT.
// reset (synchronous) empties the list; node memories keep their contents.
// depends on cdll_pkg, cdll_node_mem, cdll_free_stack
`default_nettype none
module cursor_doubly_linked_list_engine #(
   parameter int CAPACITY   = cdll_pkg::CAPACITY_DEF,
   parameter int DATA_WIDTH = cdll_pkg::DATA_WIDTH_DEF,
   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
   localparam int CW = $clog2(CAPACITY + 1)
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [cdll_pkg::OP_W-1:0]        req_op,
   input  wire logic signed [cdll_pkg::VALUE_W-1:0] req_value,
   input  wire logic [cdll_pkg::POS_W-1:0]       req_position,
   input  wire logic                             req_want_max,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [cdll_pkg::STATUS_W-1:0]         rsp_status,
   output logic                                  rsp_moved,
   output logic signed [cdll_pkg::VALUE_W-1:0]   rsp_data,
   output logic [cdll_pkg::COUNT_W-1:0]          rsp_element_count
);
   typedef enum logic [3:0] {
      S_IDLE, S_DISPATCH, S_LOOK, S_INS_NODE, S_INS_LINK, S_DEL,
      S_WALK, S_MAX, S_FINISH, S_CUR_RD, S_CUR_WAIT, S_OUT
   } state_type;

   state_type          state_ff, state_in;
   cdll_pkg::op_type   op_ff, op_in;
   logic [DATA_WIDTH-1:0] val_ff, val_in;
   logic [cdll_pkg::POS_W-1:0] pos_ff, pos_in;
   logic               wmax_ff, wmax_in;
   logic [AW-1:0]      head_ff, head_in, tail_ff, tail_in, cur_ff, cur_in;
   logic [CW-1:0]      count_ff, count_in, ftop_ff, ftop_in, fresh_ff, fresh_in;
   logic [AW-1:0]      node_ff, node_in, nb_ff, nb_in;
   logic [CW-1:0]      step_ff, step_in;
   logic [DATA_WIDTH-1:0] best_ff, best_in;
   logic               pend_ff, pend_in;
   logic               rv_ff, rv_in, mv_ff, mv_in;
   logic [cdll_pkg::STATUS_W-1:0] st_ff, st_in;
   logic [DATA_WIDTH-1:0] dat_ff, dat_in;
   // response word, held while stalled
   logic [cdll_pkg::STATUS_W-1:0] ost_ff, ost_in;
   logic               omv_ff, omv_in;
   logic [DATA_WIDTH-1:0] odat_ff, odat_in;
   logic [CW-1:0]      ocnt_ff, ocnt_in;

   logic [AW-1:0]      rd_addr;
   logic [DATA_WIDTH-1:0] rd_value;
   logic [AW-1:0]      rd_next, rd_prev, fs_data, fs_addr;
   logic               wv_en, wn_en, wp_en, fs_en;
   logic [AW-1:0]      wv_addr, wn_addr, wn_data, wp_addr, wp_data;
   logic [DATA_WIDTH-1:0] wv_data;

   cdll_node_mem #(.CAPACITY(CAPACITY), .DATA_WIDTH(DATA_WIDTH)) u_mem (
      .clock(clock), .rd_addr(rd_addr), .rd_value(rd_value), .rd_next(rd_next),
      .rd_prev(rd_prev), .wr_value_en(wv_en), .wr_value_addr(wv_addr),
      .wr_value(wv_data), .wr_next_en(wn_en), .wr_next_addr(wn_addr),
      .wr_next(wn_data), .wr_prev_en(wp_en), .wr_prev_addr(wp_addr),
      .wr_prev(wp_data));

   cdll_free_stack #(.CAPACITY(CAPACITY)) u_free (
      .clock(clock), .rd_addr(fs_addr), .rd_data(fs_data), .wr_en(fs_en),
      .wr_addr(ftop_ff[AW-1:0]), .wr_data(cur_ff));

   assign req_stall         = (state_ff != S_IDLE);
   assign rsp_valid         = rv_ff;
   assign rsp_status        = ost_ff;
   assign rsp_moved         = omv_ff;
   assign rsp_data          = cdll_pkg::VALUE_W'(signed'(odat_ff));
   assign rsp_element_count = cdll_pkg::COUNT_W'(ocnt_ff);

   logic full, is_pop;
   assign full   = (count_ff == CW'(CAPACITY));
   assign is_pop = (ftop_ff != '0);
   // pop address: top minus one
   assign fs_addr = AW'(ftop_ff - CW'(1));

   always_comb begin
      state_in = state_ff; op_in = op_ff; val_in = val_ff; pos_in = pos_ff;
      wmax_in = wmax_ff; head_in = head_ff; tail_in = tail_ff; cur_in = cur_ff;
      count_in = count_ff; ftop_in = ftop_ff; fresh_in = fresh_ff;
      node_in = node_ff; nb_in = nb_ff; step_in = step_ff;
      best_in = best_ff; pend_in = pend_ff; rv_in = rv_ff; mv_in = mv_ff;
      st_in = st_ff; dat_in = dat_ff;
      ost_in = ost_ff; omv_in = omv_ff; odat_in = odat_ff; ocnt_in = ocnt_ff;
      rd_addr = cur_ff;
      wv_en = 1'b0; wv_addr = node_ff; wv_data = val_ff;
      wn_en = 1'b0; wn_addr = node_ff; wn_data = node_ff;
      wp_en = 1'b0; wp_addr = node_ff; wp_data = node_ff;
      fs_en = 1'b0;
      if (rv_ff && !rsp_stall) rv_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in   = cdll_pkg::op_type'(req_op);
               val_in  = DATA_WIDTH'(req_value);
               pos_in  = req_position;
               wmax_in = req_want_max;
               mv_in   = 1'b0;
               st_in   = cdll_pkg::ST_OK;
               pend_in = 1'b0;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            // start a cursor read in case it is needed
            rd_addr = cur_ff;
            if (op_ff > cdll_pkg::OP_INDEX_READ) begin
               state_in = (count_ff == '0) ? S_FINISH : S_CUR_WAIT;
            end else if (op_ff != cdll_pkg::OP_INS_BEFORE &&
                         op_ff != cdll_pkg::OP_INS_AFTER && count_ff == '0) begin
               st_in = cdll_pkg::ST_EMPTY;
               state_in = S_FINISH;
            end else begin
               unique case (op_ff) inside
                  cdll_pkg::OP_INS_BEFORE, cdll_pkg::OP_INS_AFTER: begin
                     if (full) begin
                        st_in = cdll_pkg::ST_FULL;
                        state_in = S_CUR_WAIT;
                     end else begin
                        // pend marks a node taken from the freed stack
                        pend_in = is_pop;
                        if (is_pop) ftop_in = ftop_ff - CW'(1);
                        state_in = S_INS_NODE;
                     end
                  end
                  cdll_pkg::OP_FIRST: begin
                     cur_in = head_ff; state_in = S_CUR_RD;
                  end
                  cdll_pkg::OP_LAST: begin
                     cur_in = tail_ff; state_in = S_CUR_RD;
                  end
                  cdll_pkg::OP_WRITE: begin
                     wv_en = 1'b1; wv_addr = cur_ff; state_in = S_CUR_RD;
                  end
                  cdll_pkg::OP_READ: begin
                     if (wmax_ff) begin
                        rd_addr = head_ff; step_in = '0; pend_in = 1'b0;
                        state_in = S_MAX;
                     end else state_in = S_CUR_WAIT;
                  end
                  cdll_pkg::OP_INDEX_READ: begin
                     if (32'(pos_ff) >= 32'(count_ff)) begin
                        st_in = cdll_pkg::ST_RANGE; state_in = S_FINISH;
                     end else begin
                        rd_addr = head_ff; step_in = '0; state_in = S_WALK;
                     end
                  end
                  default: state_in = S_LOOK; // delete, next, prev: links of cursor
               endcase
            end
         end
         S_LOOK: begin
            // cursor node links are on the read port
            unique case (op_ff)
               cdll_pkg::OP_NEXT: begin
                  if (cur_ff != tail_ff) begin cur_in = rd_next; mv_in = 1'b1; end
                  state_in = S_CUR_RD;
               end
               cdll_pkg::OP_PREV: begin
                  if (cur_ff != head_ff) begin cur_in = rd_prev; mv_in = 1'b1; end
                  state_in = S_CUR_RD;
               end
               default: begin
                  // delete
                  fs_en = 1'b1;
                  ftop_in = ftop_ff + CW'(1);
                  count_in = count_ff - CW'(1);
                  if (count_ff > CW'(1)) begin
                     if (cur_ff == head_ff) begin
                        cur_in = rd_next; head_in = rd_next; state_in = S_CUR_RD;
                     end else if (cur_ff == tail_ff) begin
                        cur_in = rd_prev; tail_in = rd_prev; state_in = S_CUR_RD;
                     end else begin
                        wn_en = 1'b1; wn_addr = rd_prev; wn_data = rd_next;
                        wp_en = 1'b1; wp_addr = rd_next; wp_data = rd_prev;
                        cur_in = rd_next; state_in = S_CUR_RD;
                     end
                  end else state_in = S_FINISH;
               end
            endcase
         end
         S_INS_NODE: begin
            // freed stack read started at dispatch has landed
            if (pend_ff) begin
               node_in = fs_data;
            end else begin
               node_in = AW'(fresh_ff);
               fresh_in = fresh_ff + CW'(1);
            end
            rd_addr = cur_ff;
            state_in = S_INS_LINK;
         end
         S_INS_LINK: begin
            wv_en = 1'b1; wv_addr = node_ff; wv_data = val_ff;
            count_in = count_ff + CW'(1);
            if (count_ff == '0) begin
               wn_en = 1'b1; wn_addr = node_ff; wn_data = node_ff;
               wp_en = 1'b1; wp_addr = node_ff; wp_data = node_ff;
               head_in = node_ff; tail_in = node_ff; cur_in = node_ff;
               state_in = S_CUR_RD;
            end else if (op_ff == cdll_pkg::OP_INS_BEFORE) begin
               wn_en = 1'b1; wn_addr = node_ff; wn_data = cur_ff;
               wp_en = 1'b1; wp_addr = cur_ff; wp_data = node_ff;
               if (cur_ff == head_ff) begin
                  head_in = node_ff; nb_in = node_ff; pend_in = 1'b0;
                  state_in = S_DEL; // finish: write own prev
               end else begin
                  nb_in = rd_prev; pend_in = 1'b1; state_in = S_DEL;
               end
            end else begin
               wp_en = 1'b1; wp_addr = node_ff; wp_data = cur_ff;
               wn_en = 1'b1; wn_addr = cur_ff; wn_data = node_ff;
               if (cur_ff == tail_ff) begin
                  tail_in = node_ff; nb_in = node_ff; pend_in = 1'b0;
               end else begin
                  nb_in = rd_next; pend_in = 1'b1;
               end
               state_in = S_DEL;
            end
         end
         S_DEL: begin
            // second link pass of an insert
            if (op_ff == cdll_pkg::OP_INS_BEFORE) begin
               wp_en = 1'b1; wp_addr = node_ff; wp_data = nb_ff;
               if (pend_ff) begin wn_en = 1'b1; wn_addr = nb_ff; wn_data = node_ff; end
            end else begin
               wn_en = 1'b1; wn_addr = node_ff; wn_data = nb_ff;
               if (pend_ff) begin wp_en = 1'b1; wp_addr = nb_ff; wp_data = node_ff; end
            end
            state_in = S_CUR_RD;
         end
         S_WALK: begin
            // read data of walk node is on the port
            if (step_ff == CW'(pos_ff)) begin
               dat_in = rd_value; state_in = S_OUT;
            end else begin
               rd_addr = rd_next; step_in = step_ff + CW'(1);
            end
         end
         S_MAX: begin
            if (!pend_ff || $signed(best_ff) < $signed(rd_value)) best_in = rd_value;
            pend_in = 1'b1;
            if (step_ff + CW'(1) == count_ff) begin
               dat_in = (!pend_ff || $signed(best_ff) < $signed(rd_value)) ?
                        rd_value : best_ff;
               state_in = S_OUT;
            end else begin
               rd_addr = rd_next; step_in = step_ff + CW'(1);
            end
         end
         S_CUR_RD: begin
            rd_addr = cur_in;
            state_in = (count_ff == '0) ? S_FINISH : S_CUR_WAIT;
         end
         S_CUR_WAIT: begin
            dat_in = rd_value; state_in = S_OUT;
         end
         S_FINISH: begin
            dat_in = '0; state_in = S_OUT;
         end
         S_OUT: begin
            if (!rv_ff || !rsp_stall) begin
               ost_in = st_ff; omv_in = mv_ff; odat_in = dat_ff; ocnt_in = count_ff;
               rv_in = 1'b1; state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; head_ff <= '0; tail_ff <= '0; cur_ff <= '0;
         count_ff <= '0; ftop_ff <= '0; fresh_ff <= '0; rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in; head_ff <= head_in; tail_ff <= tail_in;
         cur_ff <= cur_in; count_ff <= count_in; ftop_ff <= ftop_in;
         fresh_ff <= fresh_in; rv_ff <= rv_in;
      end
      op_ff <= op_in; val_ff <= val_in; pos_ff <= pos_in; wmax_ff <= wmax_in;
      node_ff <= node_in; nb_ff <= nb_in; step_ff <= step_in;
      best_ff <= best_in; pend_ff <= pend_in; mv_ff <= mv_in; st_ff <= st_in;
      dat_ff <= dat_in;
      ost_ff <= ost_in; omv_ff <= omv_in; odat_ff <= odat_in; ocnt_ff <= ocnt_in;
   end
endmodule
`default_nettype wire

// ===== design/cdll_node_mem.sv =====
// node pool: value, forward link and backward link memories
// one write per array per cycle, registered read at one address; uses cdll_pkg
`default_nettype none
module cdll_node_mem #(
   parameter int CAPACITY   = cdll_pkg::CAPACITY_DEF,
   parameter int DATA_WIDTH = cdll_pkg::DATA_WIDTH_DEF,
   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
   input  wire logic                  clock,
   input  wire logic [AW-1:0]         rd_addr,
   output logic [DATA_WIDTH-1:0]      rd_value,
   output logic [AW-1:0]              rd_next,
   output logic [AW-1:0]              rd_prev,
   input  wire logic                  wr_value_en,
   input  wire logic [AW-1:0]         wr_value_addr,
   input  wire logic [DATA_WIDTH-1:0] wr_value,
   input  wire logic                  wr_next_en,
   input  wire logic [AW-1:0]         wr_next_addr,
   input  wire logic [AW-1:0]         wr_next,
   input  wire logic                  wr_prev_en,
   input  wire logic [AW-1:0]         wr_prev_addr,
   input  wire logic [AW-1:0]         wr_prev
);
   logic [DATA_WIDTH-1:0] value_mem [CAPACITY];
   logic [AW-1:0]         next_mem  [CAPACITY];
   logic [AW-1:0]         prev_mem  [CAPACITY];

   always_ff @(posedge clock) begin
      if (wr_value_en) value_mem[wr_value_addr] <= wr_value;
      if (wr_next_en)  next_mem[wr_next_addr]   <= wr_next;
      if (wr_prev_en)  prev_mem[wr_prev_addr]   <= wr_prev;
      rd_value <= value_mem[rd_addr];
      rd_next  <= next_mem[rd_addr];
      rd_prev  <= prev_mem[rd_addr];
   end
endmodule
`default_nettype wire

// ===== design/cdll_free_stack.sv =====
// stack of freed node indices
// push and pop one entry, registered read of the top; uses cdll_pkg
`default_nettype none
module cdll_free_stack #(
   parameter int CAPACITY = cdll_pkg::CAPACITY_DEF,
   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
   input  wire logic          clock,
   input  wire logic [AW-1:0] rd_addr,
   output logic [AW-1:0]      rd_data,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [AW-1:0] wr_data
);
   logic [AW-1:0] stack_mem [CAPACITY];

   always_ff @(posedge clock) begin
      if (wr_en) stack_mem[wr_addr] <= wr_data;
      rd_data <= stack_mem[rd_addr];
   end
endmodule
`default_nettype wire

// ===== tb/sv/tb_cursor_doubly_linked_list_engine.sv =====
// testbench for the cursor doubly linked list engine: directed and random operation words,
// each response checked against a behavioural list model held here
// depends on cdll_pkg and cursor_doubly_linked_list_engine
`timescale 1ns / 1ps
module tb_cursor_doubly_linked_list_engine;

   localparam int CAP = 256;
   // op codes with no operation behind them
   localparam logic [3:0] OP_SPARE_LO = 4'd12;
   localparam logic [3:0] OP_SPARE_HI = 4'd15;

   typedef struct packed {
      logic [1:0]  status;
      logic        moved;
      logic [31:0] data;
      logic [8:0]  count;
   } list_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [3:0] req_op = '0;
   logic signed [31:0] req_value = '0;
   logic [7:0] req_position = '0;
   logic req_want_max = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_status;
   logic rsp_moved;
   logic signed [31:0] rsp_data;
   logic [8:0] rsp_element_count;

   cursor_doubly_linked_list_engine dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_op(req_op),
      .req_value(req_value), .req_position(req_position), .req_want_max(req_want_max),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .rsp_moved(rsp_moved), .rsp_data(rsp_data), .rsp_element_count(rsp_element_count)
   );

   always #6 clock = ~clock;

   // behavioural list state
   logic [31:0] m_val [CAP];
   logic [7:0]  m_next [CAP];
   logic [7:0]  m_prev [CAP];
   logic [7:0]  m_freed [CAP];
   int unsigned m_freed_top, m_fresh, m_head, m_tail, m_cur, m_count;

   list_result_type expected_results[$];
   int mismatches = 0;
   int burst_left = 0;
   bit stall_mode = 0;

   function automatic int unsigned grab_node();
      int unsigned n;
      if (m_freed_top > 0) begin
         m_freed_top--;
         return m_freed[m_freed_top];
      end
      n = m_fresh;
      m_fresh++;
      return n;
   endfunction

   function automatic list_result_type apply_op(logic [3:0] op, logic [31:0] v,
                                                logic [7:0] pos, logic wmax);
      list_result_type r;
      bit have = 0;
      int unsigned c, n, p, q, i;
      logic signed [31:0] best;
      r = '0;
      c = m_cur;
      if (op <= cdll_pkg::OP_INDEX_READ && op != cdll_pkg::OP_INS_BEFORE &&
          op != cdll_pkg::OP_INS_AFTER && m_count == 0) begin
         r.status = cdll_pkg::ST_EMPTY;
      end else if (op == cdll_pkg::OP_INS_BEFORE || op == cdll_pkg::OP_INS_AFTER) begin
         if (m_count >= CAP) begin
            r.status = cdll_pkg::ST_FULL;
         end else begin
            n = grab_node();
            m_val[n] = v; m_next[n] = 8'(n); m_prev[n] = 8'(n);
            if (m_count == 0) begin
               m_head = n; m_tail = n; m_cur = n;
            end else if (op == cdll_pkg::OP_INS_BEFORE) begin
               m_next[n] = 8'(c);
               if (c == m_head) m_head = n;
               else begin
                  p = m_prev[c]; m_next[p] = 8'(n); m_prev[n] = 8'(p);
               end
               m_prev[c] = 8'(n);
            end else begin
               m_prev[n] = 8'(c);
               if (c == m_tail) m_tail = n;
               else begin
                  q = m_next[c]; m_prev[q] = 8'(n); m_next[n] = 8'(q);
               end
               m_next[c] = 8'(n);
            end
            m_count++;
         end
      end else if (op == cdll_pkg::OP_DELETE) begin
         if (m_count > 1) begin
            if (c == m_head) begin
               m_head = m_next[c]; m_cur = m_head;
            end else if (c == m_tail) begin
               m_tail = m_prev[c]; m_cur = m_tail;
            end else begin
               p = m_prev[c]; q = m_next[c];
               m_next[p] = 8'(q); m_prev[q] = 8'(p); m_cur = q;
            end
         end
         m_freed[m_freed_top] = 8'(c);
         m_freed_top++;
         m_count--;
      end else if (op == cdll_pkg::OP_NEXT) begin
         if (c != m_tail) begin
            m_cur = m_next[c]; r.moved = 1'b1;
         end
      end else if (op == cdll_pkg::OP_PREV) begin
         if (c != m_head) begin
            m_cur = m_prev[c]; r.moved = 1'b1;
         end
      end else if (op == cdll_pkg::OP_FIRST) begin
         m_cur = m_head;
      end else if (op == cdll_pkg::OP_LAST) begin
         m_cur = m_tail;
      end else if (op == cdll_pkg::OP_READ) begin
         if (wmax) begin
            p = m_head; best = m_val[p];
            for (i = 0; i < m_count; i++) begin
               if ($signed(m_val[p]) > best) best = m_val[p];
               p = m_next[p];
            end
            r.data = best; have = 1;
         end
      end else if (op == cdll_pkg::OP_WRITE) begin
         m_val[c] = v;
      end else if (op == cdll_pkg::OP_INDEX_READ) begin
         if (pos >= m_count) r.status = cdll_pkg::ST_RANGE;
         else begin
            p = m_head;
            for (i = 0; i < pos; i++) p = m_next[p];
            r.data = m_val[p]; have = 1;
         end
      end
      if (!have && m_count > 0 &&
          (r.status == cdll_pkg::ST_OK || r.status == cdll_pkg::ST_FULL))
         r.data = m_val[m_cur];
      if (r.status == cdll_pkg::ST_EMPTY || r.status == cdll_pkg::ST_RANGE) r.data = '0;
      r.count = 9'(m_count);
      return r;
   endfunction

   // one word with bursty gaps
   task automatic send_word(logic [3:0] op, logic [31:0] v, logic [7:0] pos, logic wmax);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 4);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      req_valid <= 1'b1;
      req_op <= op; req_value <= v; req_position <= pos; req_want_max <= wmax;
      expected_results.push_back(apply_op(op, v, pos, wmax));
      burst_left--;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic rnd_word(int ins_weight);
      logic [3:0] op;
      int k;
      k = $urandom_range(0, 99);
      if (k < ins_weight)
         op = 4'($urandom_range(cdll_pkg::OP_INS_BEFORE, cdll_pkg::OP_INS_AFTER));
      else if (k < 97)
         op = 4'($urandom_range(cdll_pkg::OP_DELETE, cdll_pkg::OP_INDEX_READ));
      else op = 4'($urandom_range(cdll_pkg::OP_INDEX_READ + 1, OP_SPARE_HI));
      send_word(op, $urandom, (m_count > 0 && $urandom_range(0, 3) != 0) ?
                8'($urandom_range(0, m_count - 1)) : 8'($urandom), 1'($urandom));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response word at %0t", $realtime);
         end else begin
            list_result_type e;
            e = expected_results.pop_front();
            if (e !== {rsp_status, rsp_moved, rsp_data, rsp_element_count}) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp st=%0d mv=%0d d=%h n=%0d got st=%0d mv=%0d d=%h n=%0d",
                           e.status, e.moved, e.data, e.count, rsp_status, rsp_moved,
                           rsp_data, rsp_element_count);
            end
         end
      end
   end

   // receiver stall pattern: alternates between free running and random stalls
   always @(posedge clock) begin
      if ($urandom_range(0, 63) == 0) stall_mode <= ~stall_mode;
      rsp_stall <= stall_mode ? ($urandom_range(0, 2) == 0) : 1'b0;
   end

   task automatic test_empty_list();
      for (int op = cdll_pkg::OP_DELETE; op <= cdll_pkg::OP_INDEX_READ; op++)
         send_word(4'(op), 32'h1, 8'd0, 1'b1);
      send_word(OP_SPARE_LO, 32'h0, 8'd0, 1'b0);
   endtask

   task automatic test_basic_ops();
      send_word(cdll_pkg::OP_INS_AFTER, 32'h7FFF_FFFF, 8'd0, 1'b0);
      send_word(cdll_pkg::OP_INS_BEFORE, 32'h8000_0000, 8'd0, 1'b0);
      send_word(cdll_pkg::OP_INS_AFTER, 32'hFFFF_FFFF, 8'd0, 1'b0);
      send_word(cdll_pkg::OP_PREV, 32'h0, 8'd0, 1'b0);
      send_word(cdll_pkg::OP_PREV, 32'h0, 8'd0, 1'b0);
      send_word(cdll_pkg::OP_NEXT, 32'h0, 8'd0, 1'b0);
      send_word(cdll_pkg::OP_LAST, 32'h0, 8'd0, 1'b0);
      send_word(cdll_pkg::OP_NEXT, 32'h0, 8'd0, 1'b0);
      send_word(cdll_pkg::OP_READ, 32'h0, 8'd0, 1'b1);
      send_word(cdll_pkg::OP_WRITE, 32'h0, 8'd0, 1'b1);
      send_word(cdll_pkg::OP_INDEX_READ, 32'h0, 8'd2, 1'b0);
      send_word(cdll_pkg::OP_INDEX_READ, 32'h0, 8'd255, 1'b0);
      send_word(OP_SPARE_HI, 32'h0, 8'd0, 1'b0);
      send_word(cdll_pkg::OP_FIRST, 32'h0, 8'd0, 1'b0);
      send_word(cdll_pkg::OP_DELETE, 32'h0, 8'd0, 1'b0);
      send_word(cdll_pkg::OP_LAST, 32'h0, 8'd0, 1'b0);
      send_word(cdll_pkg::OP_DELETE, 32'h0, 8'd0, 1'b0);
      send_word(cdll_pkg::OP_DELETE, 32'h0, 8'd0, 1'b0);
   endtask

   // fill the pool, probe it full, run random words, then drain it
   task automatic test_full_pool();
      while (m_count < CAP)
         send_word(4'($urandom_range(cdll_pkg::OP_INS_BEFORE, cdll_pkg::OP_INS_AFTER)),
                   $urandom, 8'd0, 1'b0);
      send_word(cdll_pkg::OP_INS_BEFORE, $urandom, 8'd0, 1'b0);
      send_word(cdll_pkg::OP_INDEX_READ, 32'h0, 8'd255, 1'b0);
      send_word(cdll_pkg::OP_READ, 32'h0, 8'd0, 1'b1);
      repeat (100) rnd_word(10);
      while (m_count > 0) send_word(cdll_pkg::OP_DELETE, 32'h0, 8'd0, 1'b0);
   endtask

   task automatic test_random_ops();
      for (int i = 0; i < 1300; i++) rnd_word((m_count < 12) ? 60 : 30);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_list();
      test_basic_ops();
      test_full_pool();
      test_random_ops();
      req_valid <= 1'b0;
      wait (expected_results.size() == 0);
      repeat (300) @(posedge clock);
      if (mismatches == 0 && expected_results.size() == 0)
         $display("tb_cursor_doubly_linked_list_engine: PASS");
      else
         $display("tb_cursor_doubly_linked_list_engine: FAIL");
      $finish;
   end

   initial begin
      #20ms;
      $display("tb_cursor_doubly_linked_list_engine: FAIL");
      $finish;
   end
endmodule
